@@ rtl/dlt_pkg.sv @@
// dlt_pkg: shared types, codes and fixed-point constants of the daltonize core
// used by the core, dlt_gamma_fill and dlt_lane; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package dlt_pkg;

	localparam int CH_W  = 12;
	localparam int STR_W = 13;
	localparam int POW_W = 5 * CH_W + 1;
	localparam int GAMMA_TABLE_DEPTH = 4096;

	localparam logic [CH_W-1:0]  CH_MAX  = {CH_W{1'b1}};
	localparam logic [STR_W-1:0] STR_ONE = 13'd4096;

	// register indexes
	localparam logic REG_MODE     = 1'b0;
	localparam logic REG_STRENGTH = 1'b1;

	// mode codes
	localparam logic [2:0] MODE_NONE   = 3'd0;
	localparam logic [2:0] MODE_DEUTER = 3'd1;
	localparam logic [2:0] MODE_PROTAN = 3'd2;
	localparam logic [2:0] MODE_TRITAN = 3'd3;
	localparam logic [2:0] MODE_ACHRO  = 3'd4;

	// mix weights over 10000
	localparam logic [CH_W-1:0] K_DEU_G = 12'd1875;
	localparam logic [CH_W-1:0] K_DEU_B = 12'd1625;
	localparam logic [CH_W-1:0] K_PRO_G = 12'd3031;
	localparam logic [CH_W-1:0] K_PRO_B = 12'd875;
	localparam logic [CH_W-1:0] K_TRI   = 12'd3675;

	localparam logic [13:0] MIX_SCALE = 14'd10000;
	localparam logic [12:0] MIX_HALF  = 13'd5000;
	// floor(u / 10000) = (u * RECIP_MIX) >> 45 for u below 2^26
	localparam logic [31:0] RECIP_MIX = 32'd3518437209;
	localparam int          RECIP_MIX_SH = 45;

	// bt.601 luma over 1000
	localparam logic [9:0]  LUMA_WR   = 10'd299;
	localparam logic [9:0]  LUMA_WG   = 10'd587;
	localparam logic [9:0]  LUMA_WB   = 10'd114;
	localparam logic [9:0]  LUMA_HALF = 10'd500;
	// floor(u / 1000) = (u * RECIP_LUMA) >> 32 for u below 2^22
	localparam logic [22:0] RECIP_LUMA = 23'd4294968;
	localparam int          RECIP_LUMA_SH = 32;

	localparam logic [11:0] BLEND_HALF = 12'd2048;

	typedef struct packed {
		logic [CH_W-1:0] in_red;
		logic [CH_W-1:0] in_green;
		logic [CH_W-1:0] in_blue;
		logic [CH_W-1:0] in_alpha;
	} dlt_in_word_t;

	typedef struct packed {
		logic [CH_W-1:0] out_red;
		logic [CH_W-1:0] out_green;
		logic [CH_W-1:0] out_blue;
		logic [CH_W-1:0] out_alpha;
	} dlt_out_word_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} dlt_stage_en_t;

	typedef enum logic {
		FILL_RUN,
		FILL_DONE
	} dlt_fill_state_t;

endpackage

`default_nettype wire

@@ rtl/color_blind_daltonize_core.sv @@
// color_blind_daltonize_core: color-vision correction of one rgba word a cycle
// while not stalled; uses dlt_pkg, dlt_ram, dlt_gamma_fill and dlt_lane
//
//   channel | handshake            | payload
//   in      | in_valid / in_stall  | in_word (red, green, blue, alpha)
//   out     | out_valid / out_stall| out_word (red, green, blue, alpha)
//   cfg     | cfg_we               | cfg_index, cfg_wdata
//
// six register stages, one word per cycle while not stalled
// after reset the gamma ram is filled first by the step-by-step root search,
// with in_stall held high
// out_stall freezes only stages that hold a word; bubbles still close up
`timescale 1ns / 1ps
`default_nettype none

module color_blind_daltonize_core #(
	parameter int GAMMA_TABLE_DEPTH = dlt_pkg::GAMMA_TABLE_DEPTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire dlt_pkg::dlt_in_word_t         in_word,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output dlt_pkg::dlt_out_word_t             out_word,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_index,
	input  wire logic [dlt_pkg::STR_W-1:0]     cfg_wdata
);

	localparam int AW = $clog2(GAMMA_TABLE_DEPTH);
	localparam int CW = dlt_pkg::CH_W;

	logic [2:0]                 mode_q;
	logic [dlt_pkg::STR_W-1:0]  strength_q;

	dlt_pkg::dlt_stage_en_t en;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic accept;
	logic fill_busy;

	logic          fill_we;
	logic [AW-1:0] fill_addr;
	logic [CW-1:0] fill_data;
	logic [CW-1:0] gamma;

	logic [CW-1:0] alpha_s1, alpha_s2, alpha_s3, alpha_s4, alpha_s5, alpha_s6;
	logic active_s1, active_s2, active_s3, active_s4, active_s5;
	logic achro_s1, achro_s2, achro_s3, achro_s4;
	logic [21:0] lr_s1, lg_s1, lb_s1;
	logic [21:0] ls_s2;
	logic [CW-1:0] luma_s3;
	logic [44:0] lp;
	logic [AW+CW-1:0] luma_ext;
	logic [AW-1:0] gidx;

	logic active_in, achro_in;
	logic [CW-1:0] k_r, k_g, k_b;
	logic signed [12:0] d_r, d_g, d_b;
	logic signed [12:0] rg, gr, bg;
	logic [CW-1:0] res_r, res_g, res_b;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= dlt_pkg::MODE_NONE;
			strength_q <= dlt_pkg::STR_ONE;
		end else if (cfg_we) begin
			if (cfg_index == dlt_pkg::REG_MODE) begin
				mode_q <= cfg_wdata[2:0];
			end else begin
				strength_q <= (cfg_wdata > dlt_pkg::STR_ONE) ? dlt_pkg::STR_ONE : cfg_wdata;
			end
		end
	end

	// stage enables
	always_comb begin
		en.s6 = !valid_s6 || !out_stall;
		en.s5 = !valid_s5 || en.s6;
		en.s4 = !valid_s4 || en.s5;
		en.s3 = !valid_s3 || en.s4;
		en.s2 = !valid_s2 || en.s3;
		en.s1 = !valid_s1 || en.s2;
	end

	assign in_stall  = !en.s1 || fill_busy;
	assign accept    = in_valid && !in_stall;
	assign out_valid = valid_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (en.s1) begin
				valid_s1 <= accept;
			end
			if (en.s2) begin
				valid_s2 <= valid_s1;
			end
			if (en.s3) begin
				valid_s3 <= valid_s2;
			end
			if (en.s4) begin
				valid_s4 <= valid_s3;
			end
			if (en.s5) begin
				valid_s5 <= valid_s4;
			end
			if (en.s6) begin
				valid_s6 <= valid_s5;
			end
		end
	end

	// mode decode
	assign rg = $signed({1'b0, in_word.in_red}) - $signed({1'b0, in_word.in_green});
	assign gr = $signed({1'b0, in_word.in_green}) - $signed({1'b0, in_word.in_red});
	assign bg = $signed({1'b0, in_word.in_blue}) - $signed({1'b0, in_word.in_green});

	always_comb begin
		active_in = 1'b1;
		achro_in  = 1'b0;
		k_r = '0;
		k_g = '0;
		k_b = '0;
		d_r = '0;
		d_g = '0;
		d_b = '0;
		unique case (mode_q)
			dlt_pkg::MODE_DEUTER: begin
				k_g = dlt_pkg::K_DEU_G;
				d_g = rg;
				k_b = dlt_pkg::K_DEU_B;
				d_b = gr;
			end
			dlt_pkg::MODE_PROTAN: begin
				k_g = dlt_pkg::K_PRO_G;
				d_g = rg;
				k_b = dlt_pkg::K_PRO_B;
				d_b = gr;
			end
			dlt_pkg::MODE_TRITAN: begin
				k_r = dlt_pkg::K_TRI;
				d_r = bg;
				k_g = dlt_pkg::K_TRI;
				d_g = bg;
			end
			dlt_pkg::MODE_ACHRO: begin
				achro_in = 1'b1;
			end
			default: begin
				active_in = 1'b0;
			end
		endcase
	end

	// flags, alpha and luma
	assign lp       = 45'(ls_s2) * 45'(dlt_pkg::RECIP_LUMA);
	assign luma_ext = {luma_s3, {AW{1'b0}}};
	assign gidx     = luma_ext[AW+CW-1:CW];

	always_ff @(posedge clk) begin
		if (en.s1) begin
			alpha_s1  <= in_word.in_alpha;
			active_s1 <= active_in;
			achro_s1  <= achro_in;
			lr_s1     <= 22'(in_word.in_red) * 22'(dlt_pkg::LUMA_WR);
			lg_s1     <= 22'(in_word.in_green) * 22'(dlt_pkg::LUMA_WG);
			lb_s1     <= 22'(in_word.in_blue) * 22'(dlt_pkg::LUMA_WB);
		end
		if (en.s2) begin
			alpha_s2  <= alpha_s1;
			active_s2 <= active_s1;
			achro_s2  <= achro_s1;
			ls_s2     <= lr_s1 + lg_s1 + lb_s1 + 22'(dlt_pkg::LUMA_HALF);
		end
		if (en.s3) begin
			alpha_s3  <= alpha_s2;
			active_s3 <= active_s2;
			achro_s3  <= achro_s2;
			luma_s3   <= lp[dlt_pkg::RECIP_LUMA_SH+CW-1:dlt_pkg::RECIP_LUMA_SH];
		end
		if (en.s4) begin
			alpha_s4  <= alpha_s3;
			active_s4 <= active_s3;
			achro_s4  <= achro_s3;
		end
		if (en.s5) begin
			alpha_s5  <= alpha_s4;
			active_s5 <= active_s4;
		end
		if (en.s6) begin
			alpha_s6  <= alpha_s5;
		end
	end

	dlt_gamma_fill #(
		.DEPTH(GAMMA_TABLE_DEPTH)
	) u_fill (
		.clk     (clk),
		.arst_n  (arst_n),
		.busy    (fill_busy),
		.wr_en   (fill_we),
		.wr_addr (fill_addr),
		.wr_data (fill_data)
	);

	dlt_ram #(
		.WIDTH(CW),
		.DEPTH(GAMMA_TABLE_DEPTH)
	) u_gamma_ram (
		.clk   (clk),
		.we    (fill_we),
		.waddr (fill_addr),
		.wdata (fill_data),
		.re    (en.s4),
		.raddr (gidx),
		.rdata (gamma)
	);

	dlt_lane u_lane_r (
		.clk      (clk),
		.en       (en),
		.chan     (in_word.in_red),
		.coef     (k_r),
		.diff     (d_r),
		.gamma    (gamma),
		.achro    (achro_s4),
		.active   (active_s5),
		.strength (strength_q),
		.result   (res_r)
	);

	dlt_lane u_lane_g (
		.clk      (clk),
		.en       (en),
		.chan     (in_word.in_green),
		.coef     (k_g),
		.diff     (d_g),
		.gamma    (gamma),
		.achro    (achro_s4),
		.active   (active_s5),
		.strength (strength_q),
		.result   (res_g)
	);

	dlt_lane u_lane_b (
		.clk      (clk),
		.en       (en),
		.chan     (in_word.in_blue),
		.coef     (k_b),
		.diff     (d_b),
		.gamma    (gamma),
		.achro    (achro_s4),
		.active   (active_s5),
		.strength (strength_q),
		.result   (res_b)
	);

	always_comb begin
		out_word.out_red   = res_r;
		out_word.out_green = res_g;
		out_word.out_blue  = res_b;
		out_word.out_alpha = alpha_s6;
	end

	// no word leaves while the gamma ram is being filled
	a_no_out_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fill_busy |-> !out_valid)
		else $error("word in flight during gamma fill");

	// fill runs once per reset
	a_fill_once: assert property (@(posedge clk) disable iff (!arst_n)
		!fill_busy |=> !fill_busy)
		else $error("gamma fill restarted");

	// stage 1 held only when every stage is occupied and out_stall is set
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!en.s1 |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5 && valid_s6
			&& out_stall))
		else $error("stage enable chain lost a bubble");

endmodule

`default_nettype wire

@@ rtl/dlt_ram.sv @@
// dlt_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module dlt_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/dlt_gamma_fill.sv @@
// dlt_gamma_fill: fills the gamma ram after reset with floor(2^2.4 * x^0.8) entries
// steps y^5 and x^4 by forward differences; depends on dlt_pkg
`timescale 1ns / 1ps
`default_nettype none

module dlt_gamma_fill #(
	parameter int DEPTH = dlt_pkg::GAMMA_TABLE_DEPTH
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	output logic                              busy,
	output logic                              wr_en,
	output logic [$clog2(DEPTH)-1:0]          wr_addr,
	output logic [dlt_pkg::CH_W-1:0]          wr_data
);

	localparam int AW  = $clog2(DEPTH);
	localparam int CW  = dlt_pkg::CH_W;
	localparam int PW  = dlt_pkg::POW_W;
	localparam int XSH = (AW <= CW) ? CW - AW : 0;
	localparam int RSH = (AW > CW) ? AW - CW : 0;
	localparam logic [AW-1:0] REP_MASK = AW'((1 << RSH) - 1);

	// differences of (y+1)^5 at y = 0
	localparam logic [PW-1:0] N0_INIT = PW'(1);
	localparam logic [PW-1:0] N1_INIT = PW'(31);
	localparam logic [PW-1:0] N2_INIT = PW'(180);
	localparam logic [PW-1:0] N3_INIT = PW'(390);
	localparam logic [PW-1:0] N4_INIT = PW'(360);
	localparam logic [PW-1:0] N5      = PW'(120);

	// differences of x^4 at x = 0 for a step of 2^XSH
	localparam logic [PW-1:0] T1_INIT = PW'(1)  << (4 * XSH);
	localparam logic [PW-1:0] T2_INIT = PW'(14) << (4 * XSH);
	localparam logic [PW-1:0] T3_INIT = PW'(36) << (4 * XSH);
	localparam logic [PW-1:0] T4      = PW'(24) << (4 * XSH);

	dlt_pkg::dlt_fill_state_t state_q, state_nx;

	logic [AW-1:0] idx_q;
	logic [CW-1:0] y_q;
	logic [PW-1:0] n0_q, n1_q, n2_q, n3_q, n4_q;
	logic [PW-1:0] t0_q, t1_q, t2_q, t3_q;
	logic [PW-1:0] target;
	logic          run;
	logic          can_inc;
	logic          x_adv;
	logic [AW-1:0] idx_nx;

	assign target  = t0_q << CW;
	assign run     = (state_q == dlt_pkg::FILL_RUN);
	assign can_inc = (y_q != dlt_pkg::CH_MAX) && (n0_q <= target);
	assign idx_nx  = idx_q + AW'(1);
	assign x_adv   = ((idx_nx & REP_MASK) == '0);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			dlt_pkg::FILL_RUN: begin
				if (!can_inc && (&idx_q)) begin
					state_nx = dlt_pkg::FILL_DONE;
				end
			end
			dlt_pkg::FILL_DONE: begin
				state_nx = dlt_pkg::FILL_DONE;
			end
			default: begin
				state_nx = dlt_pkg::FILL_RUN;
			end
		endcase
	end

	always_comb begin
		busy    = run;
		wr_en   = run && !can_inc;
		wr_addr = idx_q;
		wr_data = y_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dlt_pkg::FILL_RUN;
			idx_q   <= '0;
			y_q     <= '0;
			n0_q    <= N0_INIT;
			n1_q    <= N1_INIT;
			n2_q    <= N2_INIT;
			n3_q    <= N3_INIT;
			n4_q    <= N4_INIT;
			t0_q    <= '0;
			t1_q    <= T1_INIT;
			t2_q    <= T2_INIT;
			t3_q    <= T3_INIT;
		end else begin
			state_q <= state_nx;
			if (run && can_inc) begin
				y_q  <= y_q + CW'(1);
				n0_q <= n0_q + n1_q;
				n1_q <= n1_q + n2_q;
				n2_q <= n2_q + n3_q;
				n3_q <= n3_q + n4_q;
				n4_q <= n4_q + N5;
			end
			if (wr_en) begin
				idx_q <= idx_nx;
				if (x_adv) begin
					t0_q <= t0_q + t1_q;
					t1_q <= t1_q + t2_q;
					t2_q <= t2_q + t3_q;
					t3_q <= t3_q + T4;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/dlt_lane.sv @@
// dlt_lane: one color channel through mix, rounding divide, clamp and blend
// six register stages driven by shared stage enables; depends on dlt_pkg
`timescale 1ns / 1ps
`default_nettype none

module dlt_lane (
	input  wire logic                          clk,
	input  wire dlt_pkg::dlt_stage_en_t        en,
	input  wire logic [dlt_pkg::CH_W-1:0]      chan,
	input  wire logic [dlt_pkg::CH_W-1:0]      coef,
	input  wire logic signed [12:0]            diff,
	input  wire logic [dlt_pkg::CH_W-1:0]      gamma,
	input  wire logic                          achro,
	input  wire logic                          active,
	input  wire logic [dlt_pkg::STR_W-1:0]     strength,
	output logic      [dlt_pkg::CH_W-1:0]      result
);

	localparam int CW = dlt_pkg::CH_W;

	logic [CW-1:0]        c_s1, c_s2, c_s3, c_s4, c_s5;
	logic [25:0]          cp_s1;
	logic signed [25:0]   kp_s1;
	logic [25:0]          u_s2;
	logic [12:0]          q_s3;
	logic [CW-1:0]        corr_s4;
	logic signed [26:0]   mult_s5;
	logic [CW-1:0]        res_s6;

	logic signed [27:0]   v;
	logic [57:0]          qp;
	logic [CW-1:0]        sel;
	logic signed [12:0]   dsel;
	logic signed [27:0]   bsum;

	assign v    = $signed({2'b00, cp_s1}) + 28'(kp_s1);
	assign qp   = 58'(u_s2) * 58'(dlt_pkg::RECIP_MIX);
	assign sel  = achro ? gamma : corr_s4;
	assign dsel = $signed({1'b0, sel}) - $signed({1'b0, c_s4});
	assign bsum = $signed({4'b0000, c_s5, 12'b0}) + 28'(mult_s5)
		+ $signed({16'b0, dlt_pkg::BLEND_HALF});

	always_ff @(posedge clk) begin
		if (en.s1) begin
			c_s1  <= chan;
			cp_s1 <= 26'(chan) * 26'(dlt_pkg::MIX_SCALE);
			kp_s1 <= $signed({1'b0, coef}) * diff;
		end
		if (en.s2) begin
			c_s2 <= c_s1;
			u_s2 <= v[27] ? 26'd0 : v[25:0] + 26'(dlt_pkg::MIX_HALF);
		end
		if (en.s3) begin
			c_s3 <= c_s2;
			q_s3 <= qp[57:dlt_pkg::RECIP_MIX_SH];
		end
		if (en.s4) begin
			c_s4    <= c_s3;
			corr_s4 <= (q_s3 > 13'(dlt_pkg::CH_MAX)) ? dlt_pkg::CH_MAX : q_s3[CW-1:0];
		end
		if (en.s5) begin
			c_s5    <= c_s4;
			mult_s5 <= 27'(dsel * $signed({1'b0, strength}));
		end
		if (en.s6) begin
			res_s6 <= active ? bsum[23:12] : c_s5;
		end
	end

	assign result = res_s6;

endmodule

`default_nettype wire
